### hdl/textured_column_pixel_shader_defines.svh
// ----------------------------------------------------------------------------
// Textured column pixel shader: assertion macros
// Shared property forms for the checker, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_COLUMN_PIXEL_SHADER_DEFINES_SVH
`define TEXTURED_COLUMN_PIXEL_SHADER_DEFINES_SVH

// Same-cycle implication
`define TCPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TCPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tcps_pkg.sv
// ----------------------------------------------------------------------------
// Textured column pixel shader package
// Word types, fixed sizes and operation codes shared by the shader modules, checker and bench.
// ----------------------------------------------------------------------------
package tcps_pkg;

	// Screen and texture geometry
	localparam int SCREEN_WIDTH    = 320;
	localparam int SCREEN_HEIGHT   = 240;
	localparam int TEXTURE_COLUMNS = 64;
	localparam int TEXTURE_ROWS    = 128;

	localparam int COL_BITS   = $clog2(TEXTURE_COLUMNS);
	localparam int ROW_BITS   = $clog2(TEXTURE_ROWS);
	localparam int TEX_DEPTH  = TEXTURE_COLUMNS * TEXTURE_ROWS;
	localparam int TEX_AW     = $clog2(TEX_DEPTH);
	localparam int CMAP_DEPTH = 256;
	localparam int CMAP_AW    = $clog2(CMAP_DEPTH);

	// Field widths
	localparam int KIND_W  = 2;
	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int IDX_W   = 13;
	localparam int VAL_W   = 8;
	localparam int ADDR_W  = 17;
	localparam int STEP_CFG_W  = 17;
	localparam int PHASE_CFG_W = 10;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 1;

	// 7.16 texture arithmetic
	localparam int FRAC_BITS   = 16;
	localparam int SLOPE_BITS  = 4;
	localparam int SLOPE_SHIFT = FRAC_BITS - 6;
	localparam int START_W     = X_W + PHASE_CFG_W;
	localparam int STEP_W      = STEP_CFG_W + 1;
	localparam int PROD_W      = Y_W + STEP_W;
	localparam int SUM_W       = FRAC_BITS + ROW_BITS;

	// Register reset values
	localparam logic [STEP_CFG_W-1:0]  BASE_STEP_RESET  = 17'd34952;
	localparam logic [PHASE_CFG_W-1:0] PHASE_MULT_RESET = 10'd131;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_MULT = 1'b1;

	// Item kinds, also used as queue operation codes
	localparam logic [KIND_W-1:0] KIND_TEX_WR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CMAP_WR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [X_W-1:0]    pos_x;
		logic [Y_W-1:0]    pos_y;
		logic [IDX_W-1:0]  table_index;
		logic [VAL_W-1:0]  table_value;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0]  pixel_value;
		logic [ADDR_W-1:0] frame_address;
		logic              column_end;
	} result_t;

	// Classified operation handed from front to back
	typedef struct packed {
		logic [KIND_W-1:0]  op;
		logic [X_W-1:0]     pos_x;
		logic [Y_W-1:0]     pos_y;
		logic [START_W-1:0] start;
		logic [STEP_W-1:0]  step;
		logic [ADDR_W-1:0]  frame_address;
		logic               column_end;
		logic [IDX_W-1:0]   table_index;
		logic [VAL_W-1:0]   table_value;
	} entry_t;

endpackage

### hdl/tcps_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per enabled cycle, read data registered (old data on write).
// ----------------------------------------------------------------------------
module tcps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Access only when enabled so the read word holds otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/tcps_front.sv
// ----------------------------------------------------------------------------
// Pixel shader front end
// Accepts items, drops ignored ones and forms column start, step and address.
// ----------------------------------------------------------------------------
module tcps_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  tcps_pkg::item_t                     item,
	input  logic [tcps_pkg::STEP_CFG_W-1:0]     base_step,
	input  logic [tcps_pkg::PHASE_CFG_W-1:0]    phase_mult,
	input  logic                                q_full,
	output logic                                q_push,
	output tcps_pkg::entry_t                    q_entry
);
	import tcps_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  keep;
	logic  free;

	// Keep draws and in-range writes, drop everything else
	always_comb begin
		case (item_s1.kind)
			KIND_TEX_WR:  keep = ({1'b0, item_s1.table_index} < (IDX_W+1)'(TEX_DEPTH));
			KIND_CMAP_WR: keep = ({1'b0, item_s1.table_index} < (IDX_W+1)'(CMAP_DEPTH));
			KIND_DRAW:    keep = 1'b1;
			default:      keep = 1'b0;
		endcase
	end

	assign q_push     = valid_s1 && keep && !q_full;
	assign free       = !valid_s1 || !keep || !q_full;
	assign item_stall = !free;

	// Capture an item whenever the stage empties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && item_valid) begin
			item_s1 <= item;
		end
	end

	// Column start fraction; the product already lies inside the texture span
	always_comb begin
		q_entry.op    = item_s1.kind;
		q_entry.pos_x = item_s1.pos_x;
		q_entry.pos_y = item_s1.pos_y;
		q_entry.start = START_W'(item_s1.pos_x) * START_W'(phase_mult);
		q_entry.step  = STEP_W'(base_step)
			+ (STEP_W'(item_s1.pos_x[SLOPE_BITS-1:0]) << SLOPE_SHIFT);
		q_entry.frame_address = ADDR_W'(item_s1.pos_y) * ADDR_W'(SCREEN_WIDTH)
			+ ADDR_W'(item_s1.pos_x);
		q_entry.column_end  = (item_s1.pos_y == Y_W'(SCREEN_HEIGHT - 1));
		q_entry.table_index = item_s1.table_index;
		q_entry.table_value = item_s1.table_value;
	end

endmodule

### hdl/tcps_queue.sv
// ----------------------------------------------------------------------------
// Pixel shader operation queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcps_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tcps_pkg::entry_t wentry,
	output logic             full,
	input  logic             pop,
	output tcps_pkg::entry_t rentry,
	output logic             empty
);
	import tcps_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rentry = slot_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wentry;
		end
	end

endmodule

### hdl/tcps_back.sv
// ----------------------------------------------------------------------------
// Pixel shader back end
// Row product, texture access, colormap access and result register.
// ----------------------------------------------------------------------------
module tcps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  tcps_pkg::entry_t q_entry,
	output logic             q_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output tcps_pkg::result_t result
);
	import tcps_pkg::*;

	logic   adv;
	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	entry_t entry_s1;
	entry_t entry_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [KIND_W-1:0] op_s3;
	logic [IDX_W-1:0]  index_s3;
	logic [VAL_W-1:0]  value_s3;
	logic [ADDR_W-1:0] addr_s3, addr_s4;
	logic              end_s3, end_s4;

	logic [SUM_W-1:0]    sum;
	logic [ROW_BITS-1:0] row;
	logic                tex_we;
	logic [TEX_AW-1:0]   tex_addr;
	logic [VAL_W-1:0]    texel;
	logic                cmap_we;
	logic [CMAP_AW-1:0]  cmap_addr;
	logic [VAL_W-1:0]    cmap_word;

	// Whole back end moves unless a finished result waits
	assign adv   = !valid_s4 || !result_stall;
	assign q_pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !q_empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && (op_s3 == KIND_DRAW);
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			entry_s1 <= q_entry;
			entry_s2 <= entry_s1;
			prod_s2  <= PROD_W'(entry_s1.pos_y) * PROD_W'(entry_s1.step);
			op_s3    <= entry_s2.op;
			index_s3 <= entry_s2.table_index;
			value_s3 <= entry_s2.table_value;
			addr_s3  <= entry_s2.frame_address;
			end_s3   <= entry_s2.column_end;
			addr_s4  <= addr_s3;
			end_s4   <= end_s3;
		end
	end

	// Texel row from start plus row product; writes share the port in order
	assign sum      = SUM_W'(entry_s2.start) + prod_s2[SUM_W-1:0];
	assign row      = sum[SUM_W-1:FRAC_BITS];
	assign tex_we   = adv && valid_s2 && (entry_s2.op == KIND_TEX_WR);
	assign tex_addr = (entry_s2.op == KIND_TEX_WR) ? entry_s2.table_index[TEX_AW-1:0]
		: {entry_s2.pos_x[COL_BITS-1:0], row};

	tcps_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TEX_DEPTH)
	) u_tex_ram (
		.clk   (clk),
		.en    (adv),
		.we    (tex_we),
		.addr  (tex_addr),
		.wdata (entry_s2.table_value),
		.rdata (texel)
	);

	// Colormap lookup of the texel; colormap writes at the same stage
	assign cmap_we   = adv && valid_s3 && (op_s3 == KIND_CMAP_WR);
	assign cmap_addr = (op_s3 == KIND_CMAP_WR) ? index_s3[CMAP_AW-1:0] : texel;

	tcps_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CMAP_DEPTH)
	) u_cmap_ram (
		.clk   (clk),
		.en    (adv),
		.we    (cmap_we),
		.addr  (cmap_addr),
		.wdata (value_s3),
		.rdata (cmap_word)
	);

	assign result_valid         = valid_s4;
	assign result.pixel_value   = cmap_word;
	assign result.frame_address = addr_s4;
	assign result.column_end    = end_s4;

endmodule

### hdl/textured_column_pixel_shader.sv
// ----------------------------------------------------------------------------
// Textured column pixel shader
// Affine column texture mapping through a colormap, one pixel per clock while
// the result side does not stall.
// Takes one item per clock while item_stall is low and returns one pixel per
// clock for draw items while result_stall is low; texel and colormap writes
// give no result. A draw's pixel passes six registers: the front stage, the
// queue slot, the back-end entry register, the row multiply, the texture RAM
// read and the colormap RAM read. The first of these loads at the edge that
// accepts the draw. A four-entry queue sits between front and back, so input
// keeps flowing while the result side stalls, until the queue fills. Writes
// travel the same pipe as draws, so a draw always sees every earlier write.
// Texture and colormap contents are undefined after reset until written.
module textured_column_pixel_shader (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  tcps_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output tcps_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [tcps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcps_pkg::CFG_W-1:0]        cfg_data
);
	import tcps_pkg::*;

	logic [STEP_CFG_W-1:0]  base_step_q;
	logic [PHASE_CFG_W-1:0] phase_mult_q;
	logic   q_full, q_push, q_empty, q_pop;
	entry_t q_wentry, q_rentry;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q  <= BASE_STEP_RESET;
			phase_mult_q <= PHASE_MULT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_STEP:  base_step_q  <= cfg_data[STEP_CFG_W-1:0];
				REG_PHASE_MULT: phase_mult_q <= cfg_data[PHASE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	tcps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.base_step  (base_step_q),
		.phase_mult (phase_mult_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_wentry)
	);

	tcps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wentry (q_wentry),
		.full   (q_full),
		.pop    (q_pop),
		.rentry (q_rentry),
		.empty  (q_empty)
	);

	tcps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_entry      (q_rentry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### hdl/tcps_checker.sv
// ----------------------------------------------------------------------------
// Pixel shader port checker
// Result channel rules and address bounds, bound to the top level.
// ----------------------------------------------------------------------------
`include "textured_column_pixel_shader_defines.svh"

module tcps_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              result_valid,
	input  logic              result_stall,
	input  tcps_pkg::result_t result
);
	import tcps_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ROW_ADDR =
		ADDR_W'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH);
	localparam logic [ADDR_W-1:0] MAX_ADDR =
		ADDR_W'(((1 << Y_W) - 1) * SCREEN_WIDTH + (1 << X_W) - 1);

	// Hold a stalled result
	`TCPS_ASSERT_NEXT(a_valid_held, result_valid && result_stall, result_valid, "result dropped while stalled")
	`TCPS_ASSERT_NEXT(a_result_held, result_valid && result_stall, $stable(result), "result changed while stalled")

	// A last-row flag must come with an address in the last row or beyond
	`TCPS_ASSERT_NOW(a_end_addr, result_valid && result.column_end, result.frame_address >= LAST_ROW_ADDR, "column end flagged above last row")

	// Address never exceeds what any coordinate pair can give
	`TCPS_ASSERT_NOW(a_addr_bound, result_valid, result.frame_address <= MAX_ADDR, "frame address out of bounds")

endmodule

bind textured_column_pixel_shader tcps_checker u_tcps_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Textured column pixel shader testbench
// Loads texture and colormap, draws pixels along columns under several
// mapping settings, and checks every pixel word against a local predictor
// of the texture walk, with random idle cycles and result back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcps_pkg::*;

	localparam int ITEMS_TOTAL  = 1300;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 80;
	localparam int WATCHDOG_MAX = 1000;
	localparam int IDLE_PCT     = 11;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Predictor state: mapping registers and both tables
	logic [STEP_CFG_W-1:0]  step_base  = BASE_STEP_RESET;
	logic [PHASE_CFG_W-1:0] phase_mult = PHASE_MULT_RESET;
	logic [VAL_W-1:0]       texels [TEX_DEPTH];
	bit                     texel_set [TEX_DEPTH];
	logic [VAL_W-1:0]       palette [CMAP_DEPTH];
	bit                     palette_set [CMAP_DEPTH];

	result_t pending_pixels [$];
	result_t want;
	int      mismatches = 0;
	int      words_sent = 0;
	int      idle_cycles = 0;
	bit      steady = 1'b0;
	int      holds_asked = 0;
	int      holds_done = 0;
	int      hold_left = 0;

	textured_column_pixel_shader dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Texture address {column, row} of the texel a draw at (x, y) fetches
	function automatic logic [TEX_AW-1:0] texel_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
		logic [31:0] start;
		logic [31:0] step;
		logic [31:0] pos;
		start = (32'(x) * 32'(phase_mult)) % (32'(TEXTURE_ROWS) << FRAC_BITS);
		step  = 32'(step_base) + (32'(x[SLOPE_BITS-1:0]) << SLOPE_SHIFT);
		pos   = start + 32'(y) * step;
		return {x[COL_BITS-1:0], pos[FRAC_BITS +: ROW_BITS]};
	endfunction

	function automatic result_t predict_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
		result_t r;
		r.pixel_value   = palette[texels[texel_addr(x, y)]];
		r.frame_address = ADDR_W'(32'(y) * SCREEN_WIDTH + 32'(x));
		r.column_end    = (32'(y) == SCREEN_HEIGHT - 1);
		return r;
	endfunction

	function automatic bit idle_pick();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic item_t random_word(logic [KIND_W-1:0] k);
		item_t w;
		w.kind        = k;
		w.pos_x       = X_W'($urandom_range(0, 2**X_W - 1));
		w.pos_y       = Y_W'($urandom_range(0, 2**Y_W - 1));
		w.table_index = IDX_W'($urandom_range(0, 2**IDX_W - 1));
		w.table_value = VAL_W'($urandom_range(0, 2**VAL_W - 1));
		return w;
	endfunction

	// Mostly on-screen columns, now and then off the right edge
	function automatic logic [X_W-1:0] random_x();
		if ($urandom_range(9) == 0)
			return X_W'($urandom_range(SCREEN_WIDTH, 2**X_W - 1));
		return X_W'($urandom_range(0, SCREEN_WIDTH - 1));
	endfunction

	task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
		$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		mismatches++;
	endtask

	// Offer one word, hold it until taken, then update the predictor
	task automatic send_word(item_t w);
		while (idle_pick()) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		case (w.kind)
			KIND_TEX_WR: begin
				if (w.table_index < TEX_DEPTH) begin
					texels[w.table_index] = w.table_value;
					texel_set[w.table_index] = 1'b1;
				end
			end
			KIND_CMAP_WR: begin
				if (w.table_index < CMAP_DEPTH) begin
					palette[w.table_index] = w.table_value;
					palette_set[w.table_index] = 1'b1;
				end
			end
			KIND_DRAW: pending_pixels.push_back(predict_pixel(w.pos_x, w.pos_y));
			default: ;
		endcase
		words_sent++;
	endtask

	// Draw one pixel, first loading any texel or colormap entry it would read
	task automatic draw_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
		item_t w;
		logic [TEX_AW-1:0] ta;
		ta = texel_addr(x, y);
		if (!texel_set[ta]) begin
			w = random_word(KIND_TEX_WR);
			w.table_index = ta;
			send_word(w);
		end
		if (!palette_set[texels[ta]]) begin
			w = random_word(KIND_CMAP_WR);
			w.table_index = IDX_W'(texels[ta]);
			send_word(w);
		end
		w = random_word(KIND_DRAW);
		w.pos_x = x;
		w.pos_y = y;
		send_word(w);
	endtask

	task automatic draw_column(logic [X_W-1:0] x, logic [Y_W-1:0] y0, int rows);
		logic [Y_W-1:0] y;
		y = y0;
		for (int i = 0; i < rows; i++) begin
			draw_pixel(x, y);
			y++;
		end
	endtask

	// Drop valid and let every pixel and trailing write leave the pipe
	task automatic drain_pipe();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mapping(logic [STEP_CFG_W-1:0] step, logic [PHASE_CFG_W-1:0] phase);
		logic [CFG_W-1:0] pdata;
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_index <= REG_BASE_STEP;
		cfg_data <= CFG_W'(step);
		@(posedge clk);
		// upper bits of the phase word are junk the block must drop
		pdata = CFG_W'($urandom);
		pdata[PHASE_CFG_W-1:0] = phase;
		cfg_index <= REG_PHASE_MULT;
		cfg_data <= pdata;
		@(posedge clk);
		cfg_we <= 1'b0;
		step_base = step;
		phase_mult = phase;
	endtask

	// Fill the whole colormap, both extreme values included
	task automatic test_palette_load();
		item_t w;
		for (int i = 0; i < CMAP_DEPTH; i++) begin
			w = random_word(KIND_CMAP_WR);
			w.table_index = IDX_W'(i);
			if (i == 0)
				w.table_value = '1;
			else if (i == CMAP_DEPTH - 1)
				w.table_value = '0;
			send_word(w);
		end
	endtask

	// Extreme coordinates, table ends, unused kind, out-of-range colormap writes
	task automatic test_corner_cases();
		item_t w;
		w = random_word(KIND_TEX_WR);
		w.table_index = '0;
		w.table_value = '0;
		send_word(w);
		w.table_index = '1;
		w.table_value = '1;
		send_word(w);
		w = random_word(KIND_CMAP_WR);
		w.table_index = IDX_W'(CMAP_DEPTH);
		send_word(w);
		w.table_index = '1;
		send_word(w);
		w = random_word(2'd3);
		send_word(w);
		draw_pixel('0, '0);
		draw_pixel(X_W'(SCREEN_WIDTH - 1), Y_W'(SCREEN_HEIGHT - 1));
		draw_pixel('0, Y_W'(SCREEN_HEIGHT - 1));
		draw_pixel(X_W'(SCREEN_WIDTH - 1), '0);
		draw_pixel(X_W'(SCREEN_WIDTH - 1), Y_W'(SCREEN_HEIGHT - 2));
		draw_pixel('1, '1);
		draw_pixel(X_W'(63), Y_W'(SCREEN_HEIGHT));
	endtask

	// Walk the mapping registers through their extremes
	task automatic test_mapping_registers();
		logic [STEP_CFG_W-1:0]  steps [5]  = '{'0, '1, '0, '1, 17'd65536};
		logic [PHASE_CFG_W-1:0] phases [5] = '{'0, '1, '1, '0, 10'd512};
		for (int s = 0; s < 5; s++) begin
			set_mapping(steps[s], phases[s]);
			draw_column('0, '0, 6);
			draw_column(X_W'(SCREEN_WIDTH - 1), Y_W'(SCREEN_HEIGHT - 5), 6);
			draw_column('1, Y_W'(250), 6);
			draw_column(random_x(), Y_W'($urandom_range(0, 255)), 8);
		end
		set_mapping(BASE_STEP_RESET, PHASE_MULT_RESET);
	endtask

	// No idling, then a long result hold-off while words keep coming
	task automatic test_backpressure();
		steady = 1'b1;
		draw_column(random_x(), '0, 60);
		holds_asked++;
		draw_column(random_x(), Y_W'(180), 60);
		draw_column(random_x(), Y_W'($urandom_range(0, 255)), 40);
		steady = 1'b0;
	endtask

	// Column runs with random content, mixed with noise and remapping
	task automatic test_random_traffic();
		int since_map;
		int pick;
		item_t w;
		since_map = 0;
		while (words_sent < ITEMS_TOTAL) begin
			pick = $urandom_range(99);
			if (pick < 5 && since_map > 150) begin
				set_mapping(STEP_CFG_W'($urandom), PHASE_CFG_W'($urandom));
				since_map = 0;
			end else if (pick < 70) begin
				draw_column(random_x(), Y_W'($urandom_range(0, 255)), $urandom_range(1, 16));
				since_map += 8;
			end else begin
				w = random_word(KIND_W'($urandom_range(0, 3)));
				if (w.kind == KIND_DRAW)
					draw_pixel(w.pos_x, w.pos_y);
				else begin
					if (w.kind == KIND_CMAP_WR && $urandom_range(1))
						w.table_index = IDX_W'($urandom_range(0, CMAP_DEPTH - 1));
					send_word(w);
				end
				since_map++;
			end
		end
	endtask

	// Result side: random stalls, quiet while steady, long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_asked != holds_done) begin
			result_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			result_stall <= idle_pick();
		end
	end

	// Compare each pixel word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel, frame_address", 32'(0),
					32'(result.frame_address));
			end else begin
				want = pending_pixels.pop_front();
				if (result.pixel_value !== want.pixel_value)
					report_mismatch("pixel_value", 32'(want.pixel_value),
						32'(result.pixel_value));
				if (result.frame_address !== want.frame_address)
					report_mismatch("frame_address", 32'(want.frame_address),
						32'(result.frame_address));
				if (result.column_end !== want.column_end)
					report_mismatch("column_end", 32'(want.column_end),
						32'(result.column_end));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_MAX) begin
			$display("simulation failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_palette_load();
		test_corner_cases();
		test_mapping_registers();
		test_backpressure();
		test_random_traffic();
		drain_pipe();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/tcps_pkg.sv
hdl/tcps_ram.sv
hdl/tcps_front.sv
hdl/tcps_queue.sv
hdl/tcps_back.sv
hdl/textured_column_pixel_shader.sv
hdl/tcps_checker.sv
bench/testbench.sv
